// ===== hdl/regex_spec_tokenizer_core_macros.svh =====
// Assertion macros for the tokenizer core. Empty when SYNTHESIS is set.
`ifndef REGEX_SPEC_TOKENIZER_CORE_MACROS_SVH
`define REGEX_SPEC_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RXTOK_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rxtok: same-cycle check failed");

// Next-cycle implication.
`define RXTOK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rxtok: next-cycle check failed");

`else

`define RXTOK_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RXTOK_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/rxtok_pkg.sv =====
package rxtok_pkg;

    typedef enum logic [4:0] {
        TK_SETSTARTNEG = 5'd0,
        TK_SETSTART    = 5'd1,
        TK_DASHSETEND  = 5'd2,
        TK_SETEND      = 5'd3,
        TK_OPENPAREN   = 5'd4,
        TK_CLOSEPAREN  = 5'd5,
        TK_SLASH       = 5'd6,
        TK_STAR        = 5'd7,
        TK_PLUS        = 5'd8,
        TK_QUESTION    = 5'd9,
        TK_DASH        = 5'd10,
        TK_PIPE        = 5'd11,
        TK_CHAR        = 5'd12,
        TK_CLASS       = 5'd13,
        TK_TOKEN       = 5'd14,
        TK_IGNORE      = 5'd15,
        TK_ID          = 5'd16,
        TK_EOI         = 5'd17,
        TK_INVALID     = 5'd18,
        TK_TOOLONG     = 5'd19
    } tok_kind_t;

    typedef enum logic [1:0] {
        HOLD_NONE    = 2'd0,
        HOLD_BRACKET = 2'd1,
        HOLD_DASH    = 2'd2,
        HOLD_ESCAPE  = 2'd3
    } hold_t;

    typedef enum logic [1:0] {
        KW_CLASS,
        KW_TOKEN,
        KW_IGNORE
    } kw_t;

    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
    endfunction

    // Escape letters n t f v r map to control codes; anything else stands for itself.
    function automatic logic [7:0] esc_map(logic [7:0] c);
        logic [7:0] r;
        case (c)
            "n":     r = 8'h0A;
            "t":     r = 8'h09;
            "f":     r = 8'h0C;
            "v":     r = 8'h0B;
            "r":     r = 8'h0D;
            default: r = c;
        endcase
        return r;
    endfunction

    // Keyword letter at a position; zero past the end never matches an identifier byte.
    function automatic logic [7:0] kw_char(kw_t kw, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (kw)
            KW_CLASS: begin
                case (pos)
                    3'd0:    ch = "c";
                    3'd1:    ch = "l";
                    3'd2:    ch = "a";
                    3'd3:    ch = "s";
                    3'd4:    ch = "s";
                    default: ch = 8'h00;
                endcase
            end
            KW_TOKEN: begin
                case (pos)
                    3'd0:    ch = "t";
                    3'd1:    ch = "o";
                    3'd2:    ch = "k";
                    3'd3:    ch = "e";
                    3'd4:    ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            KW_IGNORE: begin
                case (pos)
                    3'd0:    ch = "i";
                    3'd1:    ch = "g";
                    3'd2:    ch = "n";
                    3'd3:    ch = "o";
                    3'd4:    ch = "r";
                    3'd5:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/regex_spec_tokenizer_core.sv =====
// Channel | Handshake          | Payload
// --------+--------------------+---------------------------------------------
// input   | s_valid / s_ready  | s_kind, s_char_value, s_aggregate_mode
// result  | m_valid / m_ready  | m_token_kind, m_token_char, m_last_of_run
//
// One character is taken per cycle while no identifier run is being emitted and the
// result channel is free. A run of N buffered characters leaves the identifier RAM
// one per cycle while results are taken; an overlong run leaves as one TK_TOOLONG
// token. Input is held off (s_ready low) for that whole flush and while a second
// token caused by the same transaction waits; result stalls simply hold. Reset is
// synchronous on aresetn, active low; no clearing pass is needed.
`include "regex_spec_tokenizer_core_macros.svh"

module regex_spec_tokenizer_core #(
    parameter int MAX_IDENT_LEN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_char_value,
    input  logic       s_aggregate_mode,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_token_kind,
    output logic [7:0] m_token_char,
    output logic       m_last_of_run
);

    localparam int LEN_W  = $clog2(MAX_IDENT_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_IDENT_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_TAIL
    } state_t;

    // Control state
    state_t               state_reg,      state_next;
    rxtok_pkg::hold_t     held_reg,       held_next;
    logic                 slash_reg,      slash_next;
    logic                 comment_reg,    comment_next;
    logic [LEN_W-1:0]     len_reg,        len_next;
    logic                 ovf_reg,        ovf_next;
    logic                 kw_class_reg,   kw_class_next;
    logic                 kw_token_reg,   kw_token_next;
    logic                 kw_ignore_reg,  kw_ignore_next;
    logic                 lead_digit_reg, lead_digit_next;
    logic [ADDR_W-1:0]    rd_idx_reg,     rd_idx_next;
    logic                 tail_valid_reg, tail_valid_next;
    logic                 m_valid_reg,    m_valid_next;

    // Payload
    rxtok_pkg::tok_kind_t tail_kind_reg,  tail_kind_next;
    logic [7:0]           tail_char_reg,  tail_char_next;
    rxtok_pkg::tok_kind_t m_kind_reg,     m_kind_next;
    logic [7:0]           m_char_reg,     m_char_next;
    logic                 m_last_reg,     m_last_next;

    // RAM port
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [7:0]           rd_data;

    logic                 out_free;
    logic                 accept;
    logic                 run_active;
    logic                 rd_last;
    rxtok_pkg::tok_kind_t run_kind;

    // Decode of the incoming character
    logic                 more;
    logic                 first_v;
    rxtok_pkg::tok_kind_t first_kind;
    logic [7:0]           first_char;
    logic                 tail_v;
    rxtok_pkg::tok_kind_t tail_kind;
    logic [7:0]           tail_char;
    logic                 do_flush;
    logic                 do_append;
    logic                 do_start;
    rxtok_pkg::hold_t     dec_held;
    logic                 dec_slash;
    logic                 dec_comment;
    logic                 pos_in_rng;
    logic [2:0]           pos3;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign run_active = (len_reg != '0) || ovf_reg;
    assign rd_last    = (LEN_W'(rd_idx_reg) + LEN_W'(1)) == len_reg;
    assign pos_in_rng = (len_reg >> 3) == '0;
    assign pos3       = len_reg[2:0];

    // Run tag from the flags tracked while the run was buffered
    always_comb begin
        if (kw_class_reg && len_reg == LEN_W'(5)) begin
            run_kind = rxtok_pkg::TK_CLASS;
        end else if (kw_token_reg && len_reg == LEN_W'(5)) begin
            run_kind = rxtok_pkg::TK_TOKEN;
        end else if (kw_ignore_reg && len_reg == LEN_W'(6)) begin
            run_kind = rxtok_pkg::TK_IGNORE;
        end else if (lead_digit_reg) begin
            run_kind = rxtok_pkg::TK_INVALID;
        end else begin
            run_kind = rxtok_pkg::TK_ID;
        end
    end

    // Character decode: end of input, open comment, held symbol, slash, run, then mode.
    // Emission order is first token, run flush, tail token.
    always_comb begin
        more        = 1'b1;
        first_v     = 1'b0;
        first_kind  = rxtok_pkg::TK_CHAR;
        first_char  = 8'h00;
        tail_v      = 1'b0;
        tail_kind   = rxtok_pkg::TK_CHAR;
        tail_char   = 8'h00;
        do_flush    = 1'b0;
        do_append   = 1'b0;
        do_start    = 1'b0;
        dec_held    = held_reg;
        dec_slash   = slash_reg;
        dec_comment = comment_reg;

        if (s_kind) begin
            // End of input: flush held symbol and run, then EOI
            case (held_reg)
                rxtok_pkg::HOLD_BRACKET: begin
                    first_v    = 1'b1;
                    first_kind = rxtok_pkg::TK_SETSTART;
                end
                rxtok_pkg::HOLD_DASH: begin
                    first_v    = 1'b1;
                    first_kind = rxtok_pkg::TK_DASH;
                end
                rxtok_pkg::HOLD_ESCAPE: begin
                    first_v    = 1'b1;
                    first_kind = rxtok_pkg::TK_CHAR;
                    first_char = rxtok_pkg::CH_BACKSLASH;
                end
                default: first_v = 1'b0;
            endcase
            dec_held    = rxtok_pkg::HOLD_NONE;
            dec_slash   = 1'b0;
            dec_comment = 1'b0;
            do_flush    = run_active;
            tail_v      = 1'b1;
            tail_kind   = rxtok_pkg::TK_EOI;
        end else if (comment_reg) begin
            if (s_char_value == rxtok_pkg::CH_NEWLINE) begin
                dec_comment = 1'b0;
            end
        end else begin
            if (held_reg != rxtok_pkg::HOLD_NONE) begin
                dec_held = rxtok_pkg::HOLD_NONE;
                first_v  = 1'b1;
                case (held_reg)
                    rxtok_pkg::HOLD_ESCAPE: begin
                        first_kind = rxtok_pkg::TK_CHAR;
                        first_char = rxtok_pkg::esc_map(s_char_value);
                        more       = 1'b0;
                    end
                    rxtok_pkg::HOLD_BRACKET: begin
                        if (s_char_value == rxtok_pkg::CH_CARET) begin
                            first_kind = rxtok_pkg::TK_SETSTARTNEG;
                            more       = 1'b0;
                        end else begin
                            first_kind = rxtok_pkg::TK_SETSTART;
                        end
                    end
                    default: begin
                        if (s_char_value == rxtok_pkg::CH_RBRACKET) begin
                            first_kind = rxtok_pkg::TK_DASHSETEND;
                            more       = 1'b0;
                        end else begin
                            first_kind = rxtok_pkg::TK_DASH;
                        end
                    end
                endcase
            end
            if (more && slash_reg) begin
                dec_slash = 1'b0;
                if (s_char_value == rxtok_pkg::CH_SLASH) begin
                    dec_comment = 1'b1;
                    more        = 1'b0;
                end
            end
            if (more && run_active) begin
                if (s_aggregate_mode && rxtok_pkg::is_ident(s_char_value)) begin
                    do_append = 1'b1;
                    more      = 1'b0;
                end else begin
                    do_flush = 1'b1;
                end
            end
            if (more) begin
                if (!s_aggregate_mode) begin
                    if (!rxtok_pkg::is_space(s_char_value)) begin
                        tail_v = 1'b1;
                        case (s_char_value)
                            rxtok_pkg::CH_LBRACKET: begin
                                tail_v   = 1'b0;
                                dec_held = rxtok_pkg::HOLD_BRACKET;
                            end
                            rxtok_pkg::CH_DASH: begin
                                tail_v   = 1'b0;
                                dec_held = rxtok_pkg::HOLD_DASH;
                            end
                            rxtok_pkg::CH_BACKSLASH: begin
                                tail_v   = 1'b0;
                                dec_held = rxtok_pkg::HOLD_ESCAPE;
                            end
                            rxtok_pkg::CH_RBRACKET: tail_kind = rxtok_pkg::TK_SETEND;
                            rxtok_pkg::CH_LPAREN:   tail_kind = rxtok_pkg::TK_OPENPAREN;
                            rxtok_pkg::CH_RPAREN:   tail_kind = rxtok_pkg::TK_CLOSEPAREN;
                            rxtok_pkg::CH_SLASH:    tail_kind = rxtok_pkg::TK_SLASH;
                            rxtok_pkg::CH_STAR:     tail_kind = rxtok_pkg::TK_STAR;
                            rxtok_pkg::CH_PLUS:     tail_kind = rxtok_pkg::TK_PLUS;
                            rxtok_pkg::CH_QUESTION: tail_kind = rxtok_pkg::TK_QUESTION;
                            rxtok_pkg::CH_PIPE:     tail_kind = rxtok_pkg::TK_PIPE;
                            default: begin
                                tail_kind = rxtok_pkg::TK_CHAR;
                                tail_char = s_char_value;
                            end
                        endcase
                    end
                end else if (rxtok_pkg::is_ident(s_char_value)) begin
                    do_start = 1'b1;
                end else if (s_char_value == rxtok_pkg::CH_SLASH) begin
                    dec_slash = 1'b1;
                end
            end
        end
    end

    // Next state
    always_comb begin
        state_next      = state_reg;
        held_next       = held_reg;
        slash_next      = slash_reg;
        comment_next    = comment_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        kw_class_next   = kw_class_reg;
        kw_token_next   = kw_token_reg;
        kw_ignore_next  = kw_ignore_reg;
        lead_digit_next = lead_digit_reg;
        rd_idx_next     = rd_idx_reg;
        tail_valid_next = tail_valid_reg;
        tail_kind_next  = tail_kind_reg;
        tail_char_next  = tail_char_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        wr_addr         = len_reg[ADDR_W-1:0];
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg + ADDR_W'(1);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    held_next       = dec_held;
                    slash_next      = dec_slash;
                    comment_next    = dec_comment;
                    tail_valid_next = tail_v;
                    tail_kind_next  = tail_kind;
                    tail_char_next  = tail_char;

                    if (do_append) begin
                        if (len_reg < LEN_W'(MAX_IDENT_LEN)) begin
                            wr_en          = 1'b1;
                            len_next       = len_reg + LEN_W'(1);
                            kw_class_next  = kw_class_reg && pos_in_rng && (s_char_value ==
                                             rxtok_pkg::kw_char(rxtok_pkg::KW_CLASS, pos3));
                            kw_token_next  = kw_token_reg && pos_in_rng && (s_char_value ==
                                             rxtok_pkg::kw_char(rxtok_pkg::KW_TOKEN, pos3));
                            kw_ignore_next = kw_ignore_reg && pos_in_rng && (s_char_value ==
                                             rxtok_pkg::kw_char(rxtok_pkg::KW_IGNORE, pos3));
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (do_start) begin
                        wr_en           = 1'b1;
                        wr_addr         = '0;
                        len_next        = LEN_W'(1);
                        kw_class_next   = s_char_value ==
                                          rxtok_pkg::kw_char(rxtok_pkg::KW_CLASS, 3'd0);
                        kw_token_next   = s_char_value ==
                                          rxtok_pkg::kw_char(rxtok_pkg::KW_TOKEN, 3'd0);
                        kw_ignore_next  = s_char_value ==
                                          rxtok_pkg::kw_char(rxtok_pkg::KW_IGNORE, 3'd0);
                        lead_digit_next = rxtok_pkg::is_digit(s_char_value);
                    end

                    if (first_v) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = first_kind;
                        m_char_next  = first_char;
                        m_last_next  = !do_flush && !tail_v;
                    end

                    if (do_flush) begin
                        // Prefetch entry 0; an overlong run needs no read
                        rd_en       = !ovf_reg;
                        rd_addr     = '0;
                        rd_idx_next = '0;
                        state_next  = ST_FLUSH;
                    end else if (tail_v && first_v) begin
                        state_next = ST_TAIL;
                    end else if (tail_v) begin
                        m_valid_next    = 1'b1;
                        m_kind_next     = tail_kind;
                        m_char_next     = tail_char;
                        m_last_next     = 1'b1;
                        tail_valid_next = 1'b0;
                    end
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (ovf_reg || rd_last) begin
                        m_kind_next     = ovf_reg ? rxtok_pkg::TK_TOOLONG : run_kind;
                        m_char_next     = ovf_reg ? 8'h00 : rd_data;
                        m_last_next     = !tail_valid_reg;
                        len_next        = '0;
                        ovf_next        = 1'b0;
                        kw_class_next   = 1'b0;
                        kw_token_next   = 1'b0;
                        kw_ignore_next  = 1'b0;
                        lead_digit_next = 1'b0;
                        state_next      = tail_valid_reg ? ST_TAIL : ST_IDLE;
                    end else begin
                        m_kind_next = run_kind;
                        m_char_next = rd_data;
                        m_last_next = 1'b0;
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                    end
                end
            end

            ST_TAIL: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = tail_kind_reg;
                    m_char_next     = tail_char_reg;
                    m_last_next     = 1'b1;
                    tail_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_reg       <= rxtok_pkg::HOLD_NONE;
            slash_reg      <= 1'b0;
            comment_reg    <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            kw_class_reg   <= 1'b0;
            kw_token_reg   <= 1'b0;
            kw_ignore_reg  <= 1'b0;
            lead_digit_reg <= 1'b0;
            rd_idx_reg     <= '0;
            tail_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            slash_reg      <= slash_next;
            comment_reg    <= comment_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            kw_class_reg   <= kw_class_next;
            kw_token_reg   <= kw_token_next;
            kw_ignore_reg  <= kw_ignore_next;
            lead_digit_reg <= lead_digit_next;
            rd_idx_reg     <= rd_idx_next;
            tail_valid_reg <= tail_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        tail_kind_reg <= tail_kind_next;
        tail_char_reg <= tail_char_next;
        m_kind_reg    <= m_kind_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
    end

    // Identifier buffer
    rxtok_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_IDENT_LEN),
        .ADDR_W (ADDR_W)
    ) u_ident_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_char_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid       = m_valid_reg;
    assign m_token_kind  = m_kind_reg;
    assign m_token_char  = m_char_reg;
    assign m_last_of_run = m_last_reg;

    `RXTOK_ASSERT_IMP(a_comment_excl, aclk, aresetn, comment_reg, (held_reg == rxtok_pkg::HOLD_NONE) && !slash_reg)
    `RXTOK_ASSERT_IMP(a_ovf_full, aclk, aresetn, ovf_reg, len_reg == LEN_W'(MAX_IDENT_LEN))
    `RXTOK_ASSERT_IMP(a_rd_in_run, aclk, aresetn, (state_reg == ST_FLUSH) && !ovf_reg, LEN_W'(rd_idx_reg) < len_reg)
    `RXTOK_ASSERT_IMP(a_held_no_run, aclk, aresetn, (state_reg == ST_IDLE) && (held_reg != rxtok_pkg::HOLD_NONE), !run_active)
    `RXTOK_ASSERT_IMP(a_tail_pending, aclk, aresetn, state_reg == ST_TAIL, tail_valid_reg)
    `RXTOK_ASSERT_NEXT(a_eoi_clears, aclk, aresetn, accept && s_kind, (held_reg == rxtok_pkg::HOLD_NONE) && !slash_reg && !comment_reg)

endmodule

// ===== hdl/rxtok_ram.sv =====
module rxtok_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
